// File: design/mai_pkg.sv
// Package for the Maxwellian average integrator: sequencer states, shared unit
// commands, register indexes and fixed-point constants.
// Depends on nothing; used by mai_arith and maxwellian_average_integrator.
package mai_pkg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DX, ST_DU, ST_PE, ST_PR, ST_SQ, ST_MB, ST_PW, ST_PD,
        ST_P1, ST_P2, ST_T1, ST_T2, ST_END, ST_FIN, ST_QD, ST_QM, ST_OUT
    } t_state;

    typedef enum logic {OP_MUL, OP_DIV} t_unit_op;

    typedef enum logic [2:0] {SH_21, SH_24, SH_30, SH_32, SH_46, SH_58, SH_62} t_shift;

    typedef struct packed {
        logic     start;
        t_unit_op op;
        t_shift   shift;
        logic     round;
    } t_unit_cmd;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0, STAT_ZERO_WEIGHT = 2'd1, STAT_SATURATED = 2'd2
    } t_status;

    localparam logic REG_TEMPERATURE_KT = 1'b0;
    localparam logic REG_MASS_FACTOR    = 1'b1;

    localparam logic [39:0] KT_RESET = 40'd122880000;
    localparam logic [23:0] MF_RESET = 24'hFF_FFFF;
    localparam logic [62:0] ONE_Q62  = 63'd1 << 62;
    localparam logic [63:0] EXP_BASE =
        (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
    localparam logic [63:0] TWO_OVER_ROOT_PI = 64'd1211587905;
    localparam logic [63:0] SUM_MAX = '1;
    localparam logic [47:0] AVG_MAX = '1;

endpackage

// File: design/mai_arith.sv
// Shared arithmetic unit: a 64 x 64 multiply built from four 32 x 32 partial
// products with rounding, shift and clamp, and a bit-serial restoring divider.
// Depends on mai_pkg.
module mai_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mai_pkg::t_unit_cmd i_cmd,
    input  logic [63:0]       i_op_a,
    input  logic [63:0]       i_op_b,
    input  logic [63:0]       i_rem_init,
    output logic              o_done,
    output logic [63:0]       o_result
);
    import mai_pkg::*;

    logic          r_busy, r_done, r_is_div;
    logic [5:0]    r_cnt;
    logic [63:0]   r_a, r_b, r_rem;
    logic [127:0]  r_prod, r_pp;
    t_shift        r_shift;

    logic [31:0]   m_x, m_y;
    logic [63:0]   m_p;
    logic [127:0]  pp_pos, rnd_const, sh;
    logic [64:0]   rem2;
    logic [65:0]   diff;
    logic          ge;
    logic [63:0]   mul_res;

    always_comb begin
        m_x = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        m_y = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        m_p = 64'(m_x) * 64'(m_y);
        case (r_cnt[1:0])
            2'd0:    pp_pos = {64'd0, m_p};
            2'd3:    pp_pos = {m_p, 64'd0};
            default: pp_pos = {32'd0, m_p, 32'd0};
        endcase
    end

    always_comb begin
        case (i_cmd.shift)
            SH_21:   rnd_const = 128'd1 << 20;
            SH_24:   rnd_const = 128'd1 << 23;
            SH_30:   rnd_const = 128'd1 << 29;
            SH_32:   rnd_const = 128'd1 << 31;
            SH_46:   rnd_const = 128'd1 << 45;
            SH_58:   rnd_const = 128'd1 << 57;
            default: rnd_const = 128'd1 << 61;
        endcase
        case (r_shift)
            SH_21:   sh = r_prod >> 21;
            SH_24:   sh = r_prod >> 24;
            SH_30:   sh = r_prod >> 30;
            SH_32:   sh = r_prod >> 32;
            SH_46:   sh = r_prod >> 46;
            SH_58:   sh = r_prod >> 58;
            default: sh = r_prod >> 62;
        endcase
        mul_res = (|sh[127:64]) ? SUM_MAX : sh[63:0];
    end

    always_comb begin
        rem2 = {r_rem, r_a[63]};
        diff = {1'b0, rem2} - {2'b0, r_b};
        ge   = !diff[65];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy   <= 1'b1;
                r_is_div <= (i_cmd.op == OP_DIV);
                r_shift  <= i_cmd.shift;
                r_cnt    <= '0;
                r_a      <= i_op_a;
                r_b      <= i_op_b;
                r_rem    <= i_rem_init;
                r_prod   <= i_cmd.round ? rnd_const : '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_is_div) begin
                    r_rem <= ge ? diff[63:0] : rem2[63:0];
                    r_a   <= {r_a[62:0], ge};
                    if (r_cnt == 6'd63) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    if (r_cnt <= 6'd3) begin
                        r_pp <= pp_pos;
                    end
                    if (r_cnt >= 6'd1) begin
                        r_prod <= r_prod + r_pp;
                    end
                    if (r_cnt == 6'd4) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? r_a : mul_res;

endmodule

// File: design/maxwellian_average_integrator.sv
// Top level of the Maxwellian average integrator: sequencer, sums and ports.
// Depends on mai_pkg and mai_arith.
//
//   Channel   Direction  Content
//   s_axis    in         tdata[39:0] energy, tdata[87:40] cross_section, tlast is_last
//   m_axis    out        tdata[47:0] average_cross_section, tdata[49:48] status
//   cfg       in         index 0 temperature_kt, index 1 mass_factor
//
// Each point after the first of a table runs a setup of two multiplies by the
// reciprocal of SUBDIVISIONS and then (SUBDIVISIONS+1) sub-points, each a chain
// of operations on the shared unit, where the exponent needs up to 42 multiplies.
// The last point adds a final divide and a scaling multiply. Reset is
// synchronous; the input is not ready while an item is in work, and a finished
// result waits in the output register while the next item is accepted.
module maxwellian_average_integrator #(
    parameter int SUBDIVISIONS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,   // energy, cross_section
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // average_cross_section, status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    import mai_pkg::*;

    localparam int SW = $clog2(SUBDIVISIONS + 1);
    localparam logic [SW:0]   S_EXT = (SW + 1)'(SUBDIVISIONS);
    localparam logic [SW-1:0] S_LAST = SW'(SUBDIVISIONS);
    localparam logic [39:0]   S_X = 40'(SUBDIVISIONS);
    localparam logic [47:0]   S_U = 48'(SUBDIVISIONS);
    localparam logic [63:0]   S_RECIP =
        ((64'd1 << 58) + 64'(SUBDIVISIONS) - 64'd1) / 64'(SUBDIVISIONS);

    t_state        r_state, n_state;
    logic          r_issued, n_issued;
    logic [39:0]   r_kt;
    logic [23:0]   r_mf;
    logic [39:0]   r_x_in, n_x_in, r_x0, n_x0, r_ax, n_ax, r_xq, n_xq;
    logic [47:0]   r_u_in, n_u_in, r_u0, n_u0, r_au, n_au, r_uq, n_uq;
    logic          r_last_in, n_last_in, r_have_prev, n_have_prev, r_u_down, n_u_down;
    logic [SW-1:0] r_bx, n_bx, r_xr, n_xr, r_bu, n_bu, r_ur, n_ur, r_j, n_j;
    logic [39:0]   r_ej, n_ej, r_ea, n_ea;
    logic [47:0]   r_ua, n_ua;
    logic [31:0]   r_wa, n_wa, r_w, n_w;
    logic [20:0]   r_ratio, n_ratio;
    logic [62:0]   r_acc, n_acc;
    logic [4:0]    r_bit, n_bit;
    logic [63:0]   r_p, n_p, r_q, n_q, r_s1, n_s1, r_s2, n_s2;
    logic [47:0]   r_avg, n_avg;
    t_status       r_status, n_status;
    logic          r_out_valid, n_out_valid;
    logic [55:0]   r_out_data, n_out_data;

    t_unit_cmd     cmd;
    logic [63:0]   op_a, op_b, op_rem, res;
    logic          done;

    logic [39:0]   xj, kt_eff, dx, d, x_rem_full;
    logic [47:0]   uj, du, u_rem_full;
    logic [SW:0]   xr_sum, ur_sum;
    logic          x_wrap, u_wrap, in_acc;
    logic [32:0]   w_pair;
    logic [64:0]   s1_add, s2_add;

    mai_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op_a     (op_a),
        .i_op_b     (op_b),
        .i_rem_init (op_rem),
        .o_done     (done),
        .o_result   (res)
    );

    always_comb begin
        xj     = r_x0 + r_xq;
        uj     = r_u_down ? r_u0 - r_uq : r_u0 + r_uq;
        kt_eff = (r_kt == '0) ? 40'd1 : r_kt;
        dx     = r_x_in - r_x0;
        du     = (r_u_in < r_u0) ? r_u0 - r_u_in : r_u_in - r_u0;
        x_rem_full = dx - res[39:0] * S_X;
        u_rem_full = du - res[47:0] * S_U;
        d      = r_ej - r_ea;
        xr_sum = {1'b0, r_xr} + {1'b0, r_bx};
        ur_sum = {1'b0, r_ur} + {1'b0, r_bu};
        x_wrap = xr_sum >= S_EXT;
        u_wrap = ur_sum >= S_EXT;
        w_pair = {1'b0, r_wa} + {1'b0, r_w};
        s1_add = {1'b0, r_s1} + {1'b0, res};
        s2_add = {1'b0, r_s2} + {1'b0, res};
        in_acc = i_s_axis_tvalid && (r_state == ST_IDLE);
    end

    always_comb begin
        n_state = r_state;      n_issued = r_issued;
        n_x_in = r_x_in;        n_u_in = r_u_in;       n_last_in = r_last_in;
        n_x0 = r_x0;            n_u0 = r_u0;           n_have_prev = r_have_prev;
        n_ax = r_ax;            n_bx = r_bx;           n_xq = r_xq;     n_xr = r_xr;
        n_au = r_au;            n_bu = r_bu;           n_uq = r_uq;     n_ur = r_ur;
        n_u_down = r_u_down;    n_j = r_j;             n_ej = r_ej;     n_ea = r_ea;
        n_ua = r_ua;            n_wa = r_wa;           n_w = r_w;       n_ratio = r_ratio;
        n_acc = r_acc;          n_bit = r_bit;         n_p = r_p;       n_q = r_q;
        n_s1 = r_s1;            n_s2 = r_s2;           n_avg = r_avg;   n_status = r_status;
        n_out_valid = r_out_valid;                     n_out_data = r_out_data;
        cmd = '{start: 1'b0, op: OP_MUL, shift: SH_62, round: 1'b0};
        op_a = '0;
        op_b = '0;
        op_rem = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_DX: begin
                cmd.shift = SH_58; op_a = 64'(dx); op_b = S_RECIP;
            end
            ST_DU: begin
                cmd.shift = SH_58; op_a = 64'(du); op_b = S_RECIP;
            end
            ST_PE: begin
                cmd.shift = SH_24; op_a = 64'(xj); op_b = 64'(r_mf);
            end
            ST_PR: begin
                cmd.op = OP_DIV; op_a = {8'd0, r_ej, 16'd0}; op_b = 64'(kt_eff);
            end
            ST_SQ: begin
                cmd.round = 1'b1; op_a = 64'(r_acc); op_b = 64'(r_acc);
            end
            ST_MB: begin
                cmd.round = 1'b1; op_a = 64'(r_acc); op_b = EXP_BASE;
            end
            ST_PW: begin
                cmd.shift = SH_46; op_a = 64'(r_ratio); op_b = 64'(r_acc);
            end
            ST_P1: begin
                cmd.shift = SH_32; op_a = 64'(r_ua); op_b = 64'(r_wa);
            end
            ST_P2: begin
                cmd.shift = SH_32; op_a = 64'(uj); op_b = 64'(r_w);
            end
            ST_T1: begin
                cmd.shift = SH_21; op_a = r_p; op_b = 64'(d);
            end
            ST_T2: begin
                cmd.shift = SH_21; op_a = 64'(w_pair); op_b = 64'(d);
            end
            ST_QD: begin
                cmd.op = OP_DIV; op_a = {r_s1[31:0], 32'd0}; op_b = r_s2;
                op_rem = 64'(r_s1[63:32]);
            end
            ST_QM: begin
                cmd.shift = SH_30; cmd.round = 1'b1; op_a = r_q; op_b = TWO_OVER_ROOT_PI;
            end
            default: begin
            end
        endcase

        if (!r_issued && (r_state inside {ST_DX, ST_DU, ST_PE, ST_PR, ST_SQ, ST_MB,
                                          ST_PW, ST_P1, ST_P2, ST_T1, ST_T2,
                                          ST_QD, ST_QM})) begin
            cmd.start = 1'b1;
            n_issued  = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_x_in    = i_s_axis_tdata[39:0];
                    n_u_in    = i_s_axis_tdata[87:40];
                    n_last_in = i_s_axis_tlast;
                    n_state   = (r_have_prev && i_s_axis_tdata[39:0] > r_x0) ? ST_DX : ST_END;
                end
            end
            ST_DX: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_ax     = res[39:0];
                    n_bx     = x_rem_full[SW-1:0];
                    n_u_down = r_u_in < r_u0;
                    n_state  = ST_DU;
                end
            end
            ST_DU: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_au = res[47:0];
                    n_bu = u_rem_full[SW-1:0];
                    n_xq = '0; n_xr = '0; n_uq = '0; n_ur = '0; n_j = '0;
                    n_state = ST_PE;
                end
            end
            ST_PE: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_ej     = res[39:0];
                    n_state  = ST_PR;
                end
            end
            ST_PR: begin
                if (done) begin
                    n_issued = 1'b0;
                    if (|res[63:21]) begin
                        n_w     = '0;
                        n_state = ST_PD;
                    end else begin
                        n_ratio = res[20:0];
                        n_acc   = ONE_Q62;
                        n_bit   = 5'd20;
                        n_state = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_acc    = res[62:0];
                    if (r_ratio[r_bit]) begin
                        n_state = ST_MB;
                    end else if (r_bit == '0) begin
                        n_state = ST_PW;
                    end else begin
                        n_bit = r_bit - 5'd1;
                    end
                end
            end
            ST_MB: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_acc    = res[62:0];
                    if (r_bit == '0) begin
                        n_state = ST_PW;
                    end else begin
                        n_bit   = r_bit - 5'd1;
                        n_state = ST_SQ;
                    end
                end
            end
            ST_PW: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_w      = res[31:0];
                    n_state  = ST_PD;
                end
            end
            ST_PD: begin
                if (r_j == '0) begin
                    n_ea = r_ej; n_ua = uj; n_wa = r_w;
                    n_j  = r_j + SW'(1);
                    n_xr = x_wrap ? SW'(xr_sum - S_EXT) : SW'(xr_sum);
                    n_xq = r_xq + r_ax + 40'(x_wrap);
                    n_ur = u_wrap ? SW'(ur_sum - S_EXT) : SW'(ur_sum);
                    n_uq = r_uq + r_au + 48'(u_wrap);
                    n_state = ST_PE;
                end else begin
                    n_state = ST_P1;
                end
            end
            ST_P1: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_p      = res;
                    n_state  = ST_P2;
                end
            end
            ST_P2: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_p      = r_p + res;
                    n_state  = ST_T1;
                end
            end
            ST_T1: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_s1     = s1_add[64] ? SUM_MAX : s1_add[63:0];
                    n_state  = ST_T2;
                end
            end
            ST_T2: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_s2 = s2_add[64] ? SUM_MAX : s2_add[63:0];
                    n_ea = r_ej; n_ua = uj; n_wa = r_w;
                    if (r_j == S_LAST) begin
                        n_state = ST_END;
                    end else begin
                        n_j  = r_j + SW'(1);
                        n_xr = x_wrap ? SW'(xr_sum - S_EXT) : SW'(xr_sum);
                        n_xq = r_xq + r_ax + 40'(x_wrap);
                        n_ur = u_wrap ? SW'(ur_sum - S_EXT) : SW'(ur_sum);
                        n_uq = r_uq + r_au + 48'(u_wrap);
                        n_state = ST_PE;
                    end
                end
            end
            ST_END: begin
                if (r_last_in) begin
                    n_state = ST_FIN;
                end else begin
                    n_x0 = r_x_in; n_u0 = r_u_in; n_have_prev = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (r_s2 == '0) begin
                    n_avg = '0; n_status = STAT_ZERO_WEIGHT; n_state = ST_OUT;
                end else if (r_s1[63:32] >= r_s2[31:0] && r_s2[63:32] == '0) begin
                    n_avg = AVG_MAX; n_status = STAT_SATURATED; n_state = ST_OUT;
                end else begin
                    n_status = (r_s1 == SUM_MAX || r_s2 == SUM_MAX) ? STAT_SATURATED : STAT_OK;
                    n_state  = ST_QD;
                end
            end
            ST_QD: begin
                if (done) begin
                    n_issued = 1'b0;
                    n_q      = res;
                    n_state  = ST_QM;
                end
            end
            ST_QM: begin
                if (done) begin
                    n_issued = 1'b0;
                    if (|res[63:48]) begin
                        n_avg = AVG_MAX; n_status = STAT_SATURATED;
                    end else begin
                        n_avg = res[47:0];
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_status, r_avg};
                    n_s1 = '0; n_s2 = '0; n_have_prev = 1'b0; n_x0 = '0; n_u0 = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_have_prev <= 1'b0;
            r_x0        <= '0;
            r_u0        <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_have_prev <= n_have_prev;
            r_x0        <= n_x0;
            r_u0        <= n_u0;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_in <= n_x_in;   r_u_in <= n_u_in;   r_last_in <= n_last_in;
        r_ax <= n_ax;       r_bx <= n_bx;       r_xq <= n_xq;     r_xr <= n_xr;
        r_au <= n_au;       r_bu <= n_bu;       r_uq <= n_uq;     r_ur <= n_ur;
        r_u_down <= n_u_down;                   r_j <= n_j;
        r_ej <= n_ej;       r_ea <= n_ea;       r_ua <= n_ua;     r_wa <= n_wa;
        r_w <= n_w;         r_ratio <= n_ratio; r_acc <= n_acc;   r_bit <= n_bit;
        r_p <= n_p;         r_q <= n_q;         r_avg <= n_avg;   r_status <= n_status;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kt <= KT_RESET;
            r_mf <= MF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMPERATURE_KT: r_kt <= i_cfg_data;
                REG_MASS_FACTOR:    r_mf <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

endmodule
